### rtl/mwg_pkg.sv
// Shared types, constants and helper functions of the multi-waveform generator.
// Used by mwg_cordic and multi_waveform_generator_unit; depends on nothing else.
`timescale 1ns / 1ps
package mwg_pkg;

  // Default values for the top-level parameters.
  localparam int MaxChannelsDef  = 8;
  localparam int MaxTableLog2Def = 16;
  localparam int CordicItersDef  = 16;

  // Field and register widths.
  localparam int ModeW    = 3;
  localparam int LgW      = 5;
  localparam int ChCfgW   = 4;
  localparam int DutyW    = 17;
  localparam int SampleW  = 16;
  localparam int ChanW    = 3;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 17;
  localparam int TriW     = 18;
  localparam int CordW    = 18;
  localparam int PhaseW   = 16;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] RegWaveMode  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegTableLog2 = 2'd1;
  localparam logic [CfgIdxW-1:0] RegChannels  = 2'd2;
  localparam logic [CfgIdxW-1:0] RegDutyCount = 2'd3;

  // Register values after reset.
  localparam logic [ModeW-1:0]  WaveModeRst  = 3'd0;
  localparam logic [LgW-1:0]    TableLog2Rst = 5'd10;
  localparam logic [ChCfgW-1:0] ChannelsRst  = 4'd2;
  localparam logic [DutyW-1:0]  DutyCountRst = 17'd512;

  // Arithmetic constants.
  localparam int MinTableLog2   = 2;
  localparam int CordicGainInit = 19898;
  localparam int TriMax         = 131071;
  localparam int TriMin         = -131072;
  localparam int SampleMax      = 32767;
  localparam int SampleMin      = -32768;
  localparam int AtanLen        = 24;

  typedef enum logic [ModeW-1:0] {
    MODE_SINE        = 3'd0,
    MODE_SAW_UP      = 3'd1,
    MODE_SAW_DOWN    = 3'd2,
    MODE_TRIANGLE    = 3'd3,
    MODE_SQUARE_HALF = 3'd4,
    MODE_SQUARE_DUTY = 3'd5
  } wave_mode_e;

  // Request to and response from the shared rotator.
  typedef struct packed {
    logic              start;
    logic [PhaseW-1:0] phase;
  } cordic_req_t;

  typedef struct packed {
    logic                      done;
    logic signed [SampleW-1:0] sample;
  } cordic_rsp_t;

  // Arctangent of 2^-k in units of 1/262144 turn, rounded to nearest.
  function automatic logic signed [CordW-1:0] atan_turn(input logic [4:0] k);
    logic signed [CordW-1:0] a;
    case (k)
      5'd0:    a = 18'sd32768;
      5'd1:    a = 18'sd19344;
      5'd2:    a = 18'sd10221;
      5'd3:    a = 18'sd5188;
      5'd4:    a = 18'sd2604;
      5'd5:    a = 18'sd1303;
      5'd6:    a = 18'sd652;
      5'd7:    a = 18'sd326;
      5'd8:    a = 18'sd163;
      5'd9:    a = 18'sd81;
      5'd10:   a = 18'sd41;
      5'd11:   a = 18'sd20;
      5'd12:   a = 18'sd10;
      5'd13:   a = 18'sd5;
      5'd14:   a = 18'sd3;
      5'd15:   a = 18'sd1;
      5'd16:   a = 18'sd1;
      default: a = 18'sd0;
    endcase
    return a;
  endfunction

  // Clamp to the Q1.15 sample range.
  function automatic logic signed [SampleW-1:0] sat16(input logic signed [31:0] v);
    logic signed [SampleW-1:0] r;
    if (v > 32'(SampleMax)) begin
      r = 16'(SampleMax);
    end else if (v < 32'(SampleMin)) begin
      r = 16'(SampleMin);
    end else begin
      r = v[SampleW-1:0];
    end
    return r;
  endfunction

endpackage

### rtl/multi_waveform_generator_unit.sv
// Multi-waveform oscillator top level: configuration registers, frame sequencer, output stage.
// Depends on mwg_pkg and mwg_cordic.
//
//   Channel | Direction | Handshake            | Payload
//   --------+-----------+----------------------+-------------------------------------
//   cfg     | in        | cfg_we_i             | cfg_idx_i, cfg_wdata_i
//   in      | in        | in_valid_i/in_ready_o| restart_i
//   out     | out       | out_valid_o/out_ready_i | sample_o, channel_o, last_o
//
// A frame goes through S_PREP and S_CALC, in sine mode also S_WAIT until the rotator is done,
// then S_EMIT for each channel; the iterative rotator takes one step a cycle.
// One transaction is in work at a time; in_ready_o is high only while the sequencer is idle.
// A stalled output holds its result; each output transaction moves one channel of the frame.
// Reset is asynchronous and active low; it restores register defaults and clears position
// and the triangle level.
`timescale 1ns / 1ps
module multi_waveform_generator_unit #(
  parameter int MAX_CHANNELS   = mwg_pkg::MaxChannelsDef,
  parameter int MAX_TABLE_LOG2 = mwg_pkg::MaxTableLog2Def,
  parameter int CORDIC_ITERS   = mwg_pkg::CordicItersDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [mwg_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [mwg_pkg::CfgDataW-1:0]        cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                restart_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [mwg_pkg::SampleW-1:0]  sample_o,
  output logic [mwg_pkg::ChanW-1:0]           channel_o,
  output logic                                last_o
);
  import mwg_pkg::*;

  localparam int PosW      = MAX_TABLE_LOG2;
  localparam int CntW      = $clog2(MAX_CHANNELS + 1);
  localparam int StepW     = CntW + 15;
  localparam int LvlW      = ((StepW + 1) > TriW ? (StepW + 1) : TriW) + 1;
  localparam int DutyCmpW  = PosW > DutyW ? PosW : DutyW;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_PREP = 5'b00010,
    S_CALC = 5'b00100,
    S_WAIT = 5'b01000,
    S_EMIT = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [ModeW-1:0]  wave_mode_q;
  logic [LgW-1:0]    table_log2_q;
  logic [ChCfgW-1:0] channels_q;
  logic [DutyW-1:0]  duty_q;

  logic [PosW-1:0]          position_q, position_d;
  logic signed [TriW-1:0]   tri_level_q, tri_level_d;
  logic [PosW-1:0]          i_q, i_d;
  logic [LgW-1:0]           lg_q, lg_d;
  logic [CntW-1:0]          ch_q, ch_d;
  logic [CntW-1:0]          chan_q, chan_d;
  logic [PhaseW-1:0]        scaled_q;
  logic [StepW-1:0]         step_q;
  logic                     tri_up_q, duty_hit_q;
  logic signed [SampleW-1:0] sample_q, sample_d;

  logic [LgW-1:0]           lg_eff;
  logic [CntW-1:0]          ch_eff;
  logic [4:0]               ch_wide;
  logic                     in_xfer, out_xfer, is_last;
  logic [PosW:0]            quarter, three_q, pos_sum;
  logic                     wrap;
  logic signed [LvlW-1:0]   tri_ext, step_ext, lvl, lvl_sat;
  logic signed [TriW-1:0]   tri_new;
  logic signed [PhaseW:0]   saw_up, saw_down;

  cordic_req_t cordic_req;
  cordic_rsp_t cordic_rsp;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_mode_q  <= WaveModeRst;
      table_log2_q <= TableLog2Rst;
      channels_q   <= ChannelsRst;
      duty_q       <= DutyCountRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegWaveMode:  wave_mode_q  <= cfg_wdata_i[ModeW-1:0];
        RegTableLog2: table_log2_q <= cfg_wdata_i[LgW-1:0];
        RegChannels:  channels_q   <= cfg_wdata_i[ChCfgW-1:0];
        RegDutyCount: duty_q       <= cfg_wdata_i[DutyW-1:0];
        default: ;
      endcase
    end
  end

  // Clamp table size and channel count to what the hardware supports.
  always_comb begin
    if (table_log2_q < LgW'(MinTableLog2)) begin
      lg_eff = LgW'(MinTableLog2);
    end else if (table_log2_q > LgW'(MAX_TABLE_LOG2)) begin
      lg_eff = LgW'(MAX_TABLE_LOG2);
    end else begin
      lg_eff = table_log2_q;
    end
    ch_wide = {1'b0, channels_q};
    if (ch_wide == 5'd0) begin
      ch_wide = 5'd1;
    end else if (ch_wide > 5'(MAX_CHANNELS)) begin
      ch_wide = 5'(MAX_CHANNELS);
    end
    ch_eff = CntW'(ch_wide);
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_EMIT);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_xfer    = out_valid_o && out_ready_i;
  assign is_last     = (CntW'(chan_q + CntW'(1)) == ch_q);

  assign quarter = (PosW+1)'(1) << (lg_q - LgW'(MinTableLog2));
  assign three_q = quarter + (quarter << 1);

  // Next position; reaching the table size wraps it and the triangle level.
  assign pos_sum = (PosW+1)'(i_q) + (PosW+1)'(ch_q);
  assign wrap    = ((pos_sum >> lg_q) != '0);

  // Triangle level stepped toward the current quarter's direction.
  always_comb begin
    tri_ext  = LvlW'(tri_level_q);
    step_ext = LvlW'($signed({1'b0, step_q}));
    lvl      = tri_up_q ? (tri_ext + step_ext) : (tri_ext - step_ext);
    if (lvl > LvlW'(TriMax)) begin
      lvl_sat = LvlW'(TriMax);
    end else if (lvl < LvlW'(TriMin)) begin
      lvl_sat = LvlW'(TriMin);
    end else begin
      lvl_sat = lvl;
    end
    tri_new = lvl_sat[TriW-1:0];
  end

  assign saw_up   = $signed({1'b0, scaled_q}) - 17'sd32768;
  assign saw_down = 17'sd32768 - $signed({1'b0, scaled_q});

  assign cordic_req.start = (state_q == S_CALC) && (wave_mode_q == MODE_SINE);
  assign cordic_req.phase = scaled_q;

  mwg_cordic #(
    .CORDIC_ITERS(CORDIC_ITERS)
  ) u_cordic (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (cordic_req),
    .rsp_o (cordic_rsp)
  );

  always_comb begin
    state_d     = state_q;
    position_d  = position_q;
    tri_level_d = tri_level_q;
    i_d         = i_q;
    lg_d        = lg_q;
    ch_d        = ch_q;
    chan_d      = chan_q;
    sample_d    = sample_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          lg_d   = lg_eff;
          ch_d   = ch_eff;
          chan_d = '0;
          if (restart_i || ((position_q >> lg_eff) != '0)) begin
            i_d         = '0;
            tri_level_d = '0;
          end else begin
            i_d = position_q;
          end
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        state_d = S_CALC;
      end
      S_CALC: begin
        case (wave_mode_q)
          MODE_SAW_UP:      sample_d = saw_up[SampleW-1:0];
          MODE_SAW_DOWN:    sample_d = sat16(32'(saw_down));
          MODE_TRIANGLE:    sample_d = sat16(32'(tri_new));
          MODE_SQUARE_HALF: sample_d = scaled_q[PhaseW-1] ? 16'(SampleMin) : 16'(SampleMax);
          MODE_SQUARE_DUTY: sample_d = duty_hit_q ? 16'(SampleMax) : 16'(SampleMin);
          default:          sample_d = '0;
        endcase
        if (wave_mode_q == MODE_TRIANGLE) begin
          tri_level_d = tri_new;
        end
        if (wrap) begin
          position_d  = '0;
          tri_level_d = '0;
        end else begin
          position_d = pos_sum[PosW-1:0];
        end
        state_d = (wave_mode_q == MODE_SINE) ? S_WAIT : S_EMIT;
      end
      S_WAIT: begin
        if (cordic_rsp.done) begin
          sample_d = cordic_rsp.sample;
          state_d  = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_xfer) begin
          if (is_last) begin
            state_d = S_IDLE;
          end else begin
            chan_d = chan_q + CntW'(1);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      position_q  <= '0;
      tri_level_q <= '0;
      chan_q      <= '0;
      ch_q        <= CntW'(1);
    end else begin
      state_q     <= state_d;
      position_q  <= position_d;
      tri_level_q <= tri_level_d;
      chan_q      <= chan_d;
      ch_q        <= ch_d;
    end
  end

  // Frame working registers; the shifts below are the per-frame phase and step scaling.
  always_ff @(posedge clk_i) begin
    i_q      <= i_d;
    lg_q     <= lg_d;
    sample_q <= sample_d;
    if (state_q == S_PREP) begin
      scaled_q   <= PhaseW'({i_q, 16'b0} >> lg_q);
      step_q     <= StepW'({ch_q, 17'b0} >> lg_q);
      tri_up_q   <= ((PosW+1)'(i_q) < quarter) || ((PosW+1)'(i_q) > three_q);
      duty_hit_q <= (DutyCmpW'(i_q) < DutyCmpW'(duty_q));
    end
  end

  assign sample_o  = sample_q;
  assign channel_o = ChanW'(chan_q);
  assign last_o    = is_last;

  a_one_side_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input and output side active together");

  a_ready_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_xfer && last_o) |=> in_ready_o)
    else $error("sequencer did not return to idle after the last channel");

  a_channel_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (chan_q < ch_q))
    else $error("channel index beyond frame");

  a_rotator_only_sine: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cordic_rsp.done |-> (state_q == S_WAIT))
    else $error("rotator result outside a sine frame");

endmodule

### rtl/mwg_cordic.sv
// Iterative CORDIC rotator: one rotation step per cycle on one shared add/shift unit.
// Maps a 16-bit phase (1/65536 turn) to a saturated Q1.15 sine; depends on mwg_pkg.
`timescale 1ns / 1ps
module mwg_cordic #(
  parameter int CORDIC_ITERS = mwg_pkg::CordicItersDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mwg_pkg::cordic_req_t req_i,
  output mwg_pkg::cordic_rsp_t rsp_o
);
  import mwg_pkg::*;

  localparam int KW = $clog2(CORDIC_ITERS);

  logic signed [CordW-1:0] x_q, x_d;
  logic signed [CordW-1:0] y_q, y_d;
  logic signed [CordW-1:0] ang_q, ang_d;
  logic [KW-1:0]           k_q, k_d;
  logic [1:0]              quad_q, quad_d;
  logic                    busy_q, busy_d;
  logic                    done_q, done_d;
  logic signed [CordW-1:0] dx, dy, at;
  logic signed [CordW:0]   result;

  assign dx = y_q >>> k_q;
  assign dy = x_q >>> k_q;
  assign at = atan_turn(5'(k_q));

  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    ang_d  = ang_q;
    k_d    = k_q;
    quad_d = quad_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      x_d    = CordW'(CordicGainInit);
      y_d    = '0;
      ang_d  = CordW'({req_i.phase[PhaseW-3:0], 2'b00});
      k_d    = '0;
      quad_d = req_i.phase[PhaseW-1:PhaseW-2];
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (ang_q >= 0) begin
        x_d   = x_q - dx;
        y_d   = y_q + dy;
        ang_d = ang_q - at;
      end else begin
        x_d   = x_q + dx;
        y_d   = y_q - dy;
        ang_d = ang_q + at;
      end
      k_d = k_q + KW'(1);
      if (k_q == KW'(CORDIC_ITERS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q    <= '0;
      y_q    <= '0;
      ang_q  <= '0;
      k_q    <= '0;
      quad_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      x_q    <= x_d;
      y_q    <= y_d;
      ang_q  <= ang_d;
      k_q    <= k_d;
      quad_q <= quad_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // The first quadrant is rotated; the others follow by symmetry.
  always_comb begin
    case (quad_q)
      2'd0:    result = (CordW+1)'(y_q);
      2'd1:    result = (CordW+1)'(x_q);
      2'd2:    result = -(CordW+1)'(y_q);
      default: result = -(CordW+1)'(x_q);
    endcase
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.sample = sat16(32'(result));

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("rotator finished without running");

  a_step_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (k_q <= KW'(CORDIC_ITERS - 1)))
    else $error("rotator step count out of range");

endmodule

### test/tb_multi_waveform_generator_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for multi_waveform_generator_unit: a directed table, then random
// configuration phases with bursty input and a stalling output, scored by an oscillator model.
// Depends on mwg_pkg and the RTL of the unit.
module tb_multi_waveform_generator_unit;
  import mwg_pkg::*;

  localparam int ClkPeriod      = 10;
  localparam int ChannelsLimit  = MaxChannelsDef;
  localparam int TableLog2Limit = MaxTableLog2Def;
  localparam int RotatorSteps   = CordicItersDef;
  localparam int SettleCycles   = 4;
  localparam int TailCycles     = 48;
  localparam int LongHoldCycles = 300;
  localparam int RandPhases     = 7;
  localparam int ItemsPerPhase  = 15;
  localparam int NumDirRows     = 25;
  localparam int MaxReported    = 10;

  // Modes outside the defined set; the block must output zero for them.
  localparam logic [ModeW-1:0] ModeSpare6 = 3'd6;
  localparam logic [ModeW-1:0] ModeSpare7 = 3'd7;

  // Arctangent of 2^-k in 1/262144 turn.
  localparam int AtanLut [24] = '{
    32768, 19344, 10221, 5188, 2604, 1303, 652, 326,
    163, 81, 41, 20, 10, 5, 3, 1,
    1, 0, 0, 0, 0, 0, 0, 0
  };

  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic [ChanW-1:0]          channel;
    logic                      last;
  } osc_beat_t;

  typedef struct packed {
    logic [ModeW-1:0]  mode;
    logic [LgW-1:0]    lg;
    logic [ChCfgW-1:0] ch;
    logic [DutyW-1:0]  duty;
    logic              restart;
    bit                pinned;
    int                pinned_sample;
  } dir_row_t;

  // A pinned row carries its sample value; the others are scored by the model.
  localparam dir_row_t DirRows [NumDirRows] = '{
    '{MODE_SINE,        5'd10, 4'd2,  17'd512,    1'b0, 1'b0, 0},
    '{MODE_SINE,        5'd10, 4'd2,  17'd512,    1'b0, 1'b0, 0},
    '{MODE_SAW_UP,      5'd2,  4'd1,  17'd512,    1'b1, 1'b1, -32768},
    '{MODE_SAW_UP,      5'd2,  4'd1,  17'd512,    1'b0, 1'b0, 0},
    '{MODE_SAW_UP,      5'd2,  4'd1,  17'd512,    1'b0, 1'b0, 0},
    '{MODE_SAW_UP,      5'd2,  4'd1,  17'd512,    1'b0, 1'b0, 0},
    '{MODE_SAW_DOWN,    5'd2,  4'd1,  17'd512,    1'b0, 1'b1, 32767},
    '{MODE_SAW_DOWN,    5'd2,  4'd1,  17'd512,    1'b0, 1'b0, 0},
    '{MODE_SINE,        5'd2,  4'd1,  17'd512,    1'b1, 1'b0, 0},
    '{MODE_SINE,        5'd2,  4'd1,  17'd512,    1'b0, 1'b0, 0},
    '{MODE_SINE,        5'd2,  4'd1,  17'd512,    1'b0, 1'b0, 0},
    '{MODE_SINE,        5'd2,  4'd1,  17'd512,    1'b0, 1'b0, 0},
    '{MODE_TRIANGLE,    5'd4,  4'd1,  17'd512,    1'b1, 1'b0, 0},
    '{MODE_TRIANGLE,    5'd4,  4'd1,  17'd512,    1'b0, 1'b0, 0},
    '{MODE_TRIANGLE,    5'd2,  4'd8,  17'd512,    1'b1, 1'b1, 32767},
    '{MODE_SQUARE_HALF, 5'd3,  4'd15, 17'd512,    1'b1, 1'b1, 32767},
    '{MODE_SQUARE_HALF, 5'd0,  4'd0,  17'd512,    1'b1, 1'b1, 32767},
    '{MODE_SQUARE_HALF, 5'd0,  4'd0,  17'd512,    1'b0, 1'b0, 0},
    '{MODE_SQUARE_HALF, 5'd0,  4'd0,  17'd0,      1'b0, 1'b0, 0},
    '{MODE_SQUARE_DUTY, 5'd31, 4'd9,  17'd0,      1'b1, 1'b1, -32768},
    '{MODE_SQUARE_DUTY, 5'd31, 4'd9,  17'd131071, 1'b0, 1'b1, 32767},
    '{MODE_SQUARE_DUTY, 5'd16, 4'd8,  17'd65536,  1'b0, 1'b0, 0},
    '{MODE_SAW_UP,      5'd2,  4'd1,  17'd512,    1'b0, 1'b0, 0},
    '{ModeSpare6,       5'd5,  4'd3,  17'd512,    1'b0, 1'b1, 0},
    '{ModeSpare7,       5'd5,  4'd3,  17'd512,    1'b1, 1'b1, 0}
  };

  logic                      clk_i       = 1'b0;
  logic                      rst_ni      = 1'b0;
  logic                      cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]        cfg_idx_i   = '0;
  logic [CfgDataW-1:0]       cfg_wdata_i = '0;
  logic                      in_valid_i  = 1'b0;
  logic                      in_ready_o;
  logic                      restart_i   = 1'b0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic signed [SampleW-1:0] sample_o;
  logic [ChanW-1:0]          channel_o;
  logic                      last_o;

  // Register copies and oscillator state of the model.
  logic [ModeW-1:0]  mode_sh = WaveModeRst;
  logic [LgW-1:0]    lg_sh   = TableLog2Rst;
  logic [ChCfgW-1:0] ch_sh   = ChannelsRst;
  logic [DutyW-1:0]  duty_sh = DutyCountRst;
  int unsigned       phase_pos = 0;
  int                tri_acc   = 0;

  osc_beat_t   pending_beats [$];
  int          err_cnt     = 0;
  int          items_taken = 0;
  int          burst_left  = 0;
  int unsigned rx_cycle    = 0;
  int          rx_pattern  = 0;
  int          hold_left   = 0;
  bit          first_hold_done  = 1'b0;
  bit          second_hold_done = 1'b0;

  multi_waveform_generator_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .restart_i   (restart_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sample_o    (sample_o),
    .channel_o   (channel_o),
    .last_o      (last_o)
  );

  initial begin
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic int clamp_q15(input int v);
    if (v > SampleMax) return SampleMax;
    if (v < SampleMin) return SampleMin;
    return v;
  endfunction

  // Rotation from the gain-compensated unit vector, then quadrant folding.
  function automatic int cordic_sine(input int unsigned ph);
    int          x;
    int          y;
    int          ang;
    int          dx;
    int          dy;
    int          k;
    int unsigned quad;
    quad = (ph >> 14) & 32'd3;
    x    = CordicGainInit;
    y    = 0;
    ang  = int'((ph & 32'h3FFF) << 2);
    for (k = 0; k < RotatorSteps && k < AtanLen; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (ang >= 0) begin
        x   = x - dx;
        y   = y + dy;
        ang = ang - AtanLut[k];
      end else begin
        x   = x + dx;
        y   = y - dy;
        ang = ang + AtanLut[k];
      end
    end
    case (quad)
      0:       return clamp_q15(y);
      1:       return clamp_q15(x);
      2:       return clamp_q15(-y);
      default: return clamp_q15(-x);
    endcase
  endfunction

  // Computes one frame of samples and queues one beat per channel.
  function automatic void oscillator_frame(input logic restart, input bit pinned,
                                           input int pinned_sample);
    int unsigned lg;
    int unsigned ch;
    int unsigned n;
    int unsigned i;
    int unsigned scaled;
    int unsigned duty_lim;
    int unsigned j;
    int          s;
    int          step;
    int          lvl;
    osc_beat_t   b;
    lg = lg_sh;
    if (lg < MinTableLog2) lg = MinTableLog2;
    if (lg > TableLog2Limit) lg = TableLog2Limit;
    ch = ch_sh;
    if (ch < 1) ch = 1;
    if (ch > ChannelsLimit) ch = ChannelsLimit;
    n = 32'd1 << lg;
    // A shrunken table can leave the position past its end; that counts as a restart.
    if (restart || phase_pos >= n) begin
      phase_pos = 0;
      tri_acc   = 0;
    end
    i      = phase_pos;
    scaled = (i << 16) >> lg;
    s      = 0;
    case (mode_sh)
      MODE_SINE:     s = cordic_sine(scaled);
      MODE_SAW_UP:   s = clamp_q15(int'(scaled) - 32768);
      MODE_SAW_DOWN: s = clamp_q15(32768 - int'(scaled));
      MODE_TRIANGLE: begin
        step = int'((ch << 17) >> lg);
        if (i < n / 4 || i > (n / 4) * 3) lvl = tri_acc + step;
        else lvl = tri_acc - step;
        if (lvl > TriMax) lvl = TriMax;
        if (lvl < TriMin) lvl = TriMin;
        tri_acc = lvl;
        s       = clamp_q15(lvl);
      end
      MODE_SQUARE_HALF: s = (i < n / 2) ? SampleMax : SampleMin;
      MODE_SQUARE_DUTY: begin
        duty_lim = (duty_sh > n) ? n : duty_sh;
        s        = (i < duty_lim) ? SampleMax : SampleMin;
      end
      default: s = 0;
    endcase
    if (pinned) s = pinned_sample;
    for (j = 0; j < ch; j++) begin
      b.sample  = SampleW'(s);
      b.channel = ChanW'(j);
      b.last    = (j + 1 == ch);
      pending_beats.push_back(b);
    end
    phase_pos = i + ch;
    if (phase_pos >= n) begin
      phase_pos = 0;
      tri_acc   = 0;
    end
  endfunction

  function automatic void check_beat();
    osc_beat_t want;
    if (pending_beats.size() == 0) begin
      err_cnt++;
      if (err_cnt <= MaxReported) begin
        $display("unexpected result: sample %0d channel %0d last %0b",
                 sample_o, channel_o, last_o);
      end
      return;
    end
    want = pending_beats.pop_front();
    if (want.sample !== sample_o || want.channel !== channel_o || want.last !== last_o) begin
      err_cnt++;
      if (err_cnt <= MaxReported) begin
        $display("mismatch: sample exp %0d got %0d, channel exp %0d got %0d, last exp %0b got %0b",
                 $signed(want.sample), sample_o, want.channel, channel_o, want.last, last_o);
      end
    end
  endfunction

  // Output side: the stall pattern is redrawn at random; two long hold-offs fill the block.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) check_beat();
    rx_cycle++;
    if (rx_cycle % 40 == 0) rx_pattern = $urandom_range(0, 2);
    if (!first_hold_done && items_taken >= 62) begin
      first_hold_done = 1'b1;
      hold_left       = LongHoldCycles;
    end
    if (!second_hold_done && items_taken >= 104) begin
      second_hold_done = 1'b1;
      hold_left        = LongHoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      case (rx_pattern)
        0:       out_ready_i <= 1'b1;
        1:       out_ready_i <= 1'($urandom_range(0, 1));
        default: out_ready_i <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input int unsigned val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= CfgDataW'(val);
    @(posedge clk_i);
  endtask

  task automatic apply_config(input logic [ModeW-1:0] m, input logic [LgW-1:0] l,
                              input logic [ChCfgW-1:0] c, input logic [DutyW-1:0] d,
                              input bit all_regs);
    if (all_regs || m != mode_sh) begin
      cfg_write(RegWaveMode, m);
      mode_sh = m;
    end
    if (all_regs || l != lg_sh) begin
      cfg_write(RegTableLog2, l);
      lg_sh = l;
    end
    if (all_regs || c != ch_sh) begin
      cfg_write(RegChannels, c);
      ch_sh = c;
    end
    if (all_regs || d != duty_sh) begin
      cfg_write(RegDutyCount, d);
      duty_sh = d;
    end
    cfg_we_i <= 1'b0;
  endtask

  // Holds the input off until every queued beat has come back.
  task automatic wait_idle(input int extra);
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic send_frame_req(input logic r, input bit pinned, input int pinned_sample);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    restart_i  <= r;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    oscillator_frame(r, pinned, pinned_sample);
    items_taken++;
  endtask

  initial begin : stimulus
    dir_row_t          row;
    int                r;
    int                ph;
    int                k;
    logic [ModeW-1:0]  m;
    logic [LgW-1:0]    l;
    logic [ChCfgW-1:0] c;
    logic [DutyW-1:0]  d;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (r = 0; r < NumDirRows; r++) begin
      row = DirRows[r];
      if (row.mode != mode_sh || row.lg != lg_sh || row.ch != ch_sh || row.duty != duty_sh)
      begin
        wait_idle(SettleCycles);
        apply_config(row.mode, row.lg, row.ch, row.duty, 1'b0);
      end
      send_frame_req(row.restart, row.pinned, row.pinned_sample);
    end

    // Random phases: mostly short tables so positions wrap, now and then the extremes.
    for (ph = 0; ph < RandPhases; ph++) begin
      wait_idle(SettleCycles);
      if ($urandom_range(0, 9) == 0) m = ModeW'($urandom_range(6, 7));
      else m = ModeW'($urandom_range(0, 5));
      case ($urandom_range(0, 9))
        0:       l = LgW'($urandom_range(0, 31));
        1:       l = LgW'(16);
        default: l = LgW'($urandom_range(2, 6));
      endcase
      if ($urandom_range(0, 2) == 0) c = ChCfgW'($urandom_range(0, 15));
      else c = ChCfgW'($urandom_range(1, 4));
      if ($urandom_range(0, 1) == 0) d = DutyW'($urandom_range(0, 131071));
      else d = DutyW'($urandom_range(0, 80));
      apply_config(m, l, c, d, 1'b1);
      for (k = 0; k < ItemsPerPhase; k++) begin
        send_frame_req($urandom_range(0, 7) == 0, 1'b0, 0);
      end
    end

    wait_idle(TailCycles);
    if (err_cnt == 0 && pending_beats.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
